FILE: hdl/cau_pkg.sv
// Shared constants, codes and types of the complex arithmetic unit.
package cau_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int QUEUE_DEPTH    = 4;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_SAT = 2'd1,
        ST_DZ  = 2'd2
    } t_status;

    // Classification of one beat, made by the front end
    typedef struct packed {
        t_op  op;
        logic div_zero;
    } t_class;

endpackage

FILE: hdl/cau_if.sv
// Valid/ready channel interfaces for operand and result beats.
interface cau_in_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic [1:0]          operation;
    logic signed [W-1:0] a_real;
    logic signed [W-1:0] a_imag;
    logic signed [W-1:0] b_real;
    logic signed [W-1:0] b_imag;

    modport source (output valid, operation, a_real, a_imag, b_real, b_imag, input ready);
    modport sink   (input valid, operation, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] result_real;
    logic signed [W-1:0] result_imag;
    logic [1:0]          status;

    modport source (output valid, result_real, result_imag, status, input ready);
    modport sink   (input valid, result_real, result_imag, status, output ready);
endinterface

FILE: hdl/cau_front.sv
// Front end: takes operand beats and classifies them for the queue.
module cau_front
    import cau_pkg::*;
#(
    parameter int W = DATA_WIDTH_DEF
) (
    cau_in_if.sink              i_in,
    input  logic                i_full,
    output logic                o_push,
    output t_class              o_cls,
    output logic signed [W-1:0] o_ar,
    output logic signed [W-1:0] o_ai,
    output logic signed [W-1:0] o_br,
    output logic signed [W-1:0] o_bi
);

    // Handshake: take a beat whenever the queue has room
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // Classification: operation and zero divisor
    always_comb begin
        o_cls.op       = t_op'(i_in.operation);
        o_cls.div_zero = (t_op'(i_in.operation) == OP_DIV) &&
                         (i_in.b_real == '0) && (i_in.b_imag == '0);
    end

    assign o_ar = i_in.a_real;
    assign o_ai = i_in.a_imag;
    assign o_br = i_in.b_real;
    assign o_bi = i_in.b_imag;

endmodule

FILE: hdl/cau_fifo.sv
// Short queue between the front end and the arithmetic pipeline.
module cau_fifo
    import cau_pkg::*;
#(
    parameter int EW    = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [EW-1:0] i_wdata,
    input  logic          i_pop,
    output logic [EW-1:0] o_rdata,
    output logic          o_full,
    output logic          o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [EW-1:0] r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    // Pointer and count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rp];
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

FILE: hdl/cau_back.sv
// Back end: multiply, sum, magnitude, pipelined divide, round and saturate.
module cau_back
    import cau_pkg::*;
#(
    parameter int W = DATA_WIDTH_DEF,
    parameter int F = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  t_class              i_cls,
    input  logic signed [W-1:0] i_ar,
    input  logic signed [W-1:0] i_ai,
    input  logic signed [W-1:0] i_br,
    input  logic signed [W-1:0] i_bi,
    output logic                o_pop,
    cau_out_if.source           o_out
);

    localparam int PW   = 2 * W;
    localparam int SW   = 2 * W + 1;
    localparam int MW   = SW;
    localparam int XW   = MW + F + W + 2;
    localparam int NST  = W + 1;
    localparam int HALF = (F > 0) ? (1 << ((F > 0) ? F - 1 : 0)) : 0;

    localparam logic [MW-1:0] NEG_LIM = MW'(1) << (W - 1);
    localparam logic [MW-1:0] POS_LIM = NEG_LIM - 1'b1;
    localparam logic [MW-1:0] CAP     = MW'(1) << W;

    typedef struct packed {
        logic          valid;
        t_class        cls;
        logic          neg_re;
        logic          neg_im;
        logic          ovf_re;
        logic          ovf_im;
        logic [XW-1:0] rem_re;
        logic [XW-1:0] rem_im;
        logic [W:0]    q_re;
        logic [W:0]    q_im;
        logic [PW-1:0] den;
        logic [MW-1:0] m_re;
        logic [MW-1:0] m_im;
    } t_dstage;

    // Whole pipeline moves when the output register is free or taken
    logic adv;
    assign adv   = !o_out.valid || o_out.ready;
    assign o_pop = adv && !i_empty;

    // Stage M: products and add/sub sums
    logic                r_m_valid;
    t_class              r_m_cls;
    logic signed [PW-1:0] r_m_prr, r_m_pii, r_m_pri, r_m_pir;
    logic [PW-1:0]        r_m_sr, r_m_si;
    logic signed [W:0]    r_m_sre, r_m_sim;
    logic signed [PW-1:0] n_m_prr, n_m_pii, n_m_pri, n_m_pir, n_m_srs, n_m_sis;
    logic signed [W:0]    n_m_sre, n_m_sim;

    always_comb begin
        n_m_prr = i_ar * i_br;
        n_m_pii = i_ai * i_bi;
        n_m_pri = i_ar * i_bi;
        n_m_pir = i_ai * i_br;
        n_m_srs = i_br * i_br;
        n_m_sis = i_bi * i_bi;
        if (i_cls.op == OP_SUB) begin
            n_m_sre = (W+1)'(i_ar) - (W+1)'(i_br);
            n_m_sim = (W+1)'(i_ai) - (W+1)'(i_bi);
        end else begin
            n_m_sre = (W+1)'(i_ar) + (W+1)'(i_br);
            n_m_sim = (W+1)'(i_ai) + (W+1)'(i_bi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (adv) begin
            r_m_valid <= !i_empty;
            r_m_cls   <= i_cls;
            r_m_prr   <= n_m_prr;
            r_m_pii   <= n_m_pii;
            r_m_pri   <= n_m_pri;
            r_m_pir   <= n_m_pir;
            r_m_sr    <= $unsigned(n_m_srs);
            r_m_si    <= $unsigned(n_m_sis);
            r_m_sre   <= n_m_sre;
            r_m_sim   <= n_m_sim;
        end
    end

    // Stage S: combine products or pass add/sub sums per operation; form the divisor
    logic                 r_s_valid;
    t_class               r_s_cls;
    logic signed [SW-1:0] r_s_re, r_s_im, n_s_re, n_s_im;
    logic [PW-1:0]        r_s_den;

    always_comb begin
        unique case (r_m_cls.op)
            OP_ADD, OP_SUB: begin
                n_s_re = SW'(r_m_sre);
                n_s_im = SW'(r_m_sim);
            end
            OP_MUL: begin
                n_s_re = SW'(r_m_prr) - SW'(r_m_pii);
                n_s_im = SW'(r_m_pri) + SW'(r_m_pir);
            end
            OP_DIV: begin
                n_s_re = SW'(r_m_prr) + SW'(r_m_pii);
                n_s_im = SW'(r_m_pir) - SW'(r_m_pri);
            end
            default: begin
                n_s_re = '0;
                n_s_im = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (adv) begin
            r_s_valid <= r_m_valid;
            r_s_cls   <= r_m_cls;
            r_s_re    <= n_s_re;
            r_s_im    <= n_s_im;
            r_s_den   <= r_m_sr + r_m_si;
        end
    end

    // Stage A: sign and magnitude
    logic          r_a_valid;
    t_class        r_a_cls;
    logic          r_a_neg_re, r_a_neg_im;
    logic [MW-1:0] r_a_mag_re, r_a_mag_im;
    logic [PW-1:0] r_a_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid  <= r_s_valid;
            r_a_cls    <= r_s_cls;
            r_a_neg_re <= r_s_re[SW-1];
            r_a_neg_im <= r_s_im[SW-1];
            r_a_mag_re <= r_s_re[SW-1] ? $unsigned(-r_s_re) : $unsigned(r_s_re);
            r_a_mag_im <= r_s_im[SW-1] ? $unsigned(-r_s_im) : $unsigned(r_s_im);
            r_a_den    <= r_s_den;
        end
    end

    // Stage C: product rounding, divider setup and overflow check
    t_dstage       r_d [0:NST];
    t_dstage       n_d [0:NST];
    logic [MW:0]   rnd_re, rnd_im;
    logic [XW-1:0] lim;

    always_comb begin
        rnd_re = {1'b0, r_a_mag_re} + (MW+1)'(HALF);
        rnd_im = {1'b0, r_a_mag_im} + (MW+1)'(HALF);
        lim    = XW'(r_a_den) << (W + 1);
        n_d[0].valid  = r_a_valid;
        n_d[0].cls    = r_a_cls;
        n_d[0].neg_re = r_a_neg_re;
        n_d[0].neg_im = r_a_neg_im;
        n_d[0].den    = r_a_den;
        n_d[0].rem_re = XW'(r_a_mag_re) << (F + 1);
        n_d[0].rem_im = XW'(r_a_mag_im) << (F + 1);
        n_d[0].ovf_re = (XW'(r_a_mag_re) << (F + 1)) >= lim;
        n_d[0].ovf_im = (XW'(r_a_mag_im) << (F + 1)) >= lim;
        n_d[0].q_re   = '0;
        n_d[0].q_im   = '0;
        if (r_a_cls.op == OP_MUL) begin
            n_d[0].m_re = MW'(rnd_re >> F);
            n_d[0].m_im = MW'(rnd_im >> F);
        end else begin
            n_d[0].m_re = r_a_mag_re;
            n_d[0].m_im = r_a_mag_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d[0].valid <= 1'b0;
        end else if (adv) begin
            r_d[0] <= n_d[0];
        end
    end

    // Divider: one restoring step per stage, quotient bit weight 2^(W-j)
    for (genvar j = 0; j < NST; j++) begin : g_div
        localparam int K = W - j;
        logic [XW-1:0] dsh;
        logic          b_re, b_im;

        always_comb begin
            dsh  = XW'(r_d[j].den) << K;
            b_re = r_d[j].rem_re >= dsh;
            b_im = r_d[j].rem_im >= dsh;
            n_d[j+1]        = r_d[j];
            n_d[j+1].rem_re = b_re ? r_d[j].rem_re - dsh : r_d[j].rem_re;
            n_d[j+1].rem_im = b_im ? r_d[j].rem_im - dsh : r_d[j].rem_im;
            n_d[j+1].q_re   = {r_d[j].q_re[W-1:0], b_re};
            n_d[j+1].q_im   = {r_d[j].q_im[W-1:0], b_im};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d[j+1].valid <= 1'b0;
            end else if (adv) begin
                r_d[j+1] <= n_d[j+1];
            end
        end
    end

    // Saturate a sign/magnitude pair to a W-bit code; top bit flags saturation
    function automatic logic [W:0] sat_code(input logic neg, input logic [MW-1:0] mag);
        logic          s;
        logic [W-1:0]  v;
        s = 1'b0;
        if (neg) begin
            s = mag > NEG_LIM;
            v = s ? W'(NEG_LIM) : W'(MW'(0) - mag);
        end else begin
            s = mag > POS_LIM;
            v = s ? W'(POS_LIM) : W'(mag);
        end
        return {s, v};
    endfunction

    // Final stage: divide rounding, saturation, status
    t_dstage       fin;
    logic [MW-1:0] fm_re, fm_im;
    logic [W:0]    c_re, c_im;
    logic [W+1:0]  qr_re, qr_im;

    always_comb begin
        fin   = r_d[NST];
        qr_re = ((W+2)'(fin.q_re) + 1'b1) >> 1;
        qr_im = ((W+2)'(fin.q_im) + 1'b1) >> 1;
        if (fin.cls.op == OP_DIV) begin
            fm_re = fin.ovf_re ? CAP : MW'(qr_re);
            fm_im = fin.ovf_im ? CAP : MW'(qr_im);
        end else begin
            fm_re = fin.m_re;
            fm_im = fin.m_im;
        end
        c_re = sat_code(fin.neg_re, fm_re);
        c_im = sat_code(fin.neg_im, fm_im);
    end

    // Output register
    logic                r_out_valid;
    logic signed [W-1:0] r_out_re, r_out_im;
    t_status             r_out_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= fin.valid;
            if (fin.cls.div_zero) begin
                r_out_re <= '0;
                r_out_im <= '0;
                r_out_st <= ST_DZ;
            end else begin
                r_out_re <= $signed(c_re[W-1:0]);
                r_out_im <= $signed(c_im[W-1:0]);
                r_out_st <= (c_re[W] || c_im[W]) ? ST_SAT : ST_OK;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_real = r_out_re;
    assign o_out.result_imag = r_out_im;
    assign o_out.status      = r_out_st;

endmodule

FILE: hdl/complex_arithmetic_unit.sv
// Complex arithmetic unit: each beat carries two complex operands in signed fixed point
// (FRAC_BITS fraction bits) and an operation code, and returns their sum, difference,
// product or quotient, rounded to nearest (ties away from zero), saturated to DATA_WIDTH
// bits, with status ok, saturated or divide by zero. One beat is accepted per cycle while
// the queue has room, and one result leaves per cycle while the output is ready. The
// queue entry written at the accepting edge is read out into four arithmetic stages,
// followed by DATA_WIDTH + 1 restoring divide stages that every beat passes through
// and the output register. A four-entry queue decouples input acceptance from the
// pipeline, which holds in place while a result waits on the output.
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cau_in_if.sink     i_in,
    cau_out_if.source  o_out
);

    localparam int W  = DATA_WIDTH;
    localparam int EW = $bits(t_class) + 4 * W;

    logic                push, pop, full, empty;
    t_class              f_cls, q_cls;
    logic signed [W-1:0] f_ar, f_ai, f_br, f_bi;
    logic signed [W-1:0] q_ar, q_ai, q_br, q_bi;
    logic [EW-1:0]       wdata, rdata;

    cau_front #(.W(W)) u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_cls  (f_cls),
        .o_ar   (f_ar),
        .o_ai   (f_ai),
        .o_br   (f_br),
        .o_bi   (f_bi)
    );

    assign wdata = {f_cls, f_ar, f_ai, f_br, f_bi};

    cau_fifo #(.EW(EW), .DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wdata),
        .i_pop   (pop),
        .o_rdata (rdata),
        .o_full  (full),
        .o_empty (empty)
    );

    assign {q_cls, q_ar, q_ai, q_br, q_bi} = rdata;

    cau_back #(.W(W), .F(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cls   (q_cls),
        .i_ar    (q_ar),
        .i_ai    (q_ai),
        .i_br    (q_br),
        .i_bi    (q_bi),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

FILE: hdl/cau_checker.sv
// Port-level checks of the complex arithmetic unit, bound to the top level.
module cau_checker
    import cau_pkg::*;
#(
    parameter int W = DATA_WIDTH_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic signed [W-1:0] i_result_real,
    input logic signed [W-1:0] i_result_imag,
    input logic [1:0]          i_status
);

    logic [7:0] r_cnt, n_cnt;
    logic       in_beat, out_beat;

    assign in_beat  = i_in_valid && i_in_ready;
    assign out_beat = i_out_valid && i_out_ready;

    // Beats in flight
    always_comb begin
        n_cnt = r_cnt;
        if (in_beat && !out_beat) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!in_beat && out_beat) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result_real) &&
        $stable(i_result_imag) && $stable(i_status))
        else $error("result changed while stalled");

    // No result without an earlier operand beat
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |-> r_cnt != '0)
        else $error("result without operand beat");

    // Divide by zero gives a zero result
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_DZ |-> i_result_real == '0 && i_result_imag == '0)
        else $error("divide by zero result not zero");

    // Status code is never the unused one
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status != 2'd3)
        else $error("unused status code");

endmodule

bind complex_arithmetic_unit cau_checker #(.W(DATA_WIDTH)) u_cau_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_result_real (o_out.result_real),
    .i_result_imag (o_out.result_imag),
    .i_status      (o_out.status)
);
